>>> design/bdq_pkg.sv
// Shared types and constants for the bounded deque with value delete.
// No dependencies; every other design file but bdq_ram refers to it by scoped names.
package bdq_pkg;

    // fixed field widths of the request and response words
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_BACK  = 3'd3,
        OP_REM_VALUE = 3'd4,
        OP_SEARCH    = 3'd5
    } op_t;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

>>> design/bdq_req_if.sv
// Request channel interface: valid/ready handshake with operation and value.
// Depends on bdq_pkg for the field widths.
interface bdq_req_if;
    logic                               valid;
    logic                               ready;
    logic [bdq_pkg::OP_W-1:0]           operation;
    logic signed [bdq_pkg::VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

>>> design/bdq_rsp_if.sv
// Response channel interface: valid/ready handshake with status and occupancy.
// Depends on bdq_pkg for the field widths.
interface bdq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::STATUS_W-1:0]  status;
    logic [bdq_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, output status, output occupancy, input ready);
    modport sink   (input valid, input status, input occupancy, output ready);
endinterface

>>> design/bdq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/bounded_deque_with_value_delete.sv
// Bounded deque of signed 32-bit words held in a ring buffer in one RAM, with a
// front pointer and an element count in registers. Each request word gives one
// response word. Insert and remove at either end, and any request that finds
// the store empty or full, go from acceptance through S_RESULT into the output
// register, and the next request is accepted once the sequencer is back in
// S_IDLE. Search and remove-by-value walk the elements from the front through
// the RAM read port, one element per cycle; remove-by-value then moves each
// later element one place forward, one read and one write per cycle, unless
// the match is the first or the last element, where no element moves. The
// response is held in an output register, so a new request is taken while it
// waits.
// Depends on bdq_pkg, bdq_req_if, bdq_rsp_if and bdq_ram.
module bounded_deque_with_value_delete #(
    parameter int CAPACITY = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OFF_W = IDX_W + 2;
    localparam int SUM_W = OFF_W + 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [IDX_W-1:0]                front_reg, front_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [IDX_W-1:0]                k_reg, k_next;
    logic                            remove_reg, remove_next;
    logic [bdq_pkg::VALUE_W-1:0]     value_reg, value_next;
    bdq_pkg::status_t                pend_reg, pend_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    bdq_pkg::status_t                rsp_status_reg, rsp_status_next;
    logic [bdq_pkg::OCC_W-1:0]       rsp_occ_reg, rsp_occ_next;

    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    logic [bdq_pkg::VALUE_W-1:0]     wr_data;
    logic [IDX_W-1:0]                rd_addr;
    logic [bdq_pkg::VALUE_W-1:0]     rd_data;

    logic                            accept;
    logic                            is_full;
    logic                            is_empty;
    logic [OFF_W-1:0]                k_off0;
    logic [OFF_W-1:0]                k_off1;
    logic [OFF_W-1:0]                k_off2;
    logic [OFF_W-1:0]                cnt_off;
    logic [IDX_W-1:0]                front_dec;
    logic [IDX_W-1:0]                front_inc;
    logic                            rsp_free;

    // ring index of the element off places behind the front
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                 input logic [OFF_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(off);
        if (sum >= SUM_W'(CAPACITY))
        begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    // element storage
    bdq_ram #(
        .WIDTH (bdq_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_bdq_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // handshake and helper values
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && (state_reg == S_IDLE);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign k_off0    = OFF_W'(k_reg);
    assign k_off1    = OFF_W'(k_reg) + OFF_W'(1);
    assign k_off2    = OFF_W'(k_reg) + OFF_W'(2);
    assign cnt_off   = OFF_W'(count_reg);
    assign front_dec = (front_reg == '0) ? IDX_W'(CAPACITY - 1) : front_reg - 1'b1;
    assign front_inc = slot_of(front_reg, OFF_W'(1));
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    // read address: the element needed by the next cycle
    always_comb
    begin
        unique case (state_reg)
            S_SCAN:  rd_addr = slot_of(front_reg, k_off1);
            S_SHIFT: rd_addr = slot_of(front_reg, k_off2);
            default: rd_addr = front_reg;
        endcase
    end

    // request sequencer
    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        remove_next     = remove_reg;
        value_next      = value_reg;
        pend_next       = pend_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_occ_next    = rsp_occ_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_of(front_reg, k_off0);
        wr_data         = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = S_RESULT;
                    pend_next   = bdq_pkg::ST_OK;
                    k_next      = '0;
                    value_next  = req.value;
                    remove_next = (req.operation == bdq_pkg::OP_REM_VALUE);
                    unique case (req.operation) inside
                        bdq_pkg::OP_INS_FRONT, bdq_pkg::OP_INS_BACK:
                        begin
                            if (is_full)
                            begin
                                pend_next = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_data    = req.value;
                                count_next = count_reg + 1'b1;
                                if (req.operation == bdq_pkg::OP_INS_FRONT)
                                begin
                                    wr_addr    = front_dec;
                                    front_next = front_dec;
                                end
                                else
                                begin
                                    wr_addr = slot_of(front_reg, cnt_off);
                                end
                            end
                        end
                        bdq_pkg::OP_REM_FRONT, bdq_pkg::OP_REM_BACK:
                        begin
                            if (is_empty)
                            begin
                                pend_next = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                if (req.operation == bdq_pkg::OP_REM_FRONT)
                                begin
                                    front_next = front_inc;
                                end
                            end
                        end
                        bdq_pkg::OP_REM_VALUE, bdq_pkg::OP_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                pend_next = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            pend_next = bdq_pkg::ST_OK;
                        end
                    endcase
                end
            end

            // compare element k against the key, read element k+1
            S_SCAN:
            begin
                if (rd_data == value_reg)
                begin
                    pend_next  = bdq_pkg::ST_OK;
                    state_next = S_RESULT;
                    if (remove_reg)
                    begin
                        if (k_reg == '0)
                        begin
                            front_next = front_inc;
                            count_next = count_reg - 1'b1;
                        end
                        else if (k_off1 == cnt_off)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            state_next = S_SHIFT;
                        end
                    end
                end
                else if (k_off1 >= cnt_off)
                begin
                    pend_next  = bdq_pkg::ST_NOT_FOUND;
                    state_next = S_RESULT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            // move element k+1 into slot k, read element k+2
            S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = slot_of(front_reg, k_off0);
                wr_data = rd_data;
                if (k_off2 >= cnt_off)
                begin
                    count_next = count_reg - 1'b1;
                    pend_next  = bdq_pkg::ST_OK;
                    state_next = S_RESULT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            // hand the response to the output register once it is free
            S_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = pend_reg;
                    rsp_occ_next    = bdq_pkg::OCC_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        remove_reg     <= remove_next;
        value_reg      <= value_next;
        pend_reg       <= pend_next;
        rsp_status_reg <= rsp_status_next;
        rsp_occ_reg    <= rsp_occ_next;
    end

    // response word
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.occupancy = rsp_occ_reg;

endmodule

>>> design/bdq_checker.sv
// Port-level checks for the bounded deque, bound to the top level.
// Depends on bdq_pkg and bounded_deque_with_value_delete.
module bdq_checker #(
    parameter int CAPACITY = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [bdq_pkg::STATUS_W-1:0] rsp_status,
    input logic [bdq_pkg::OCC_W-1:0]    rsp_occupancy
);

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_occupancy))
        else $error("response word changed while stalled");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in progress");

    // a full response reports a full store
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == bdq_pkg::ST_FULL)
            |-> rsp_occupancy == bdq_pkg::OCC_W'(CAPACITY))
        else $error("full status with occupancy below capacity");

    // an empty response reports no elements
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == bdq_pkg::ST_EMPTY) |-> rsp_occupancy == '0)
        else $error("empty status with nonzero occupancy");

endmodule

bind bounded_deque_with_value_delete bdq_checker #(
    .CAPACITY (CAPACITY)
) u_bdq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_occupancy (rsp.occupancy)
);
